>>> hdl/assert_macros.svh
// Concurrent assertion macros shared by the RTL of the slot table.
// Included by modules that carry assertions; depends on nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication violated");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/pstg_pkg.sv
// Package of the process slot table: sizes, codes, entry types and the
// identifier generation function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pstg_pkg;

  localparam int unsigned NumSlots = 1024;
  localparam int unsigned GenShift = 12;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned CountW   = SlotW + 1;
  localparam int unsigned IdW      = 31;
  localparam int unsigned GenW     = IdW + 1;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StW      = 2;
  localparam int unsigned TgtW     = 10;
  localparam int unsigned RunsW    = 32;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC,
    OP_LOOKUP,
    OP_DESTROY,
    OP_RUN
  } op_e;

  typedef enum logic [1:0] {
    SS_FREE,
    SS_RUNNABLE,
    SS_RUNNING,
    SS_DYING
  } slot_st_e;

  typedef enum logic [StW-1:0] {
    RS_OK,
    RS_FULL,
    RS_BAD
  } res_st_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_EXEC,
    ST_FIX
  } state_e;

  typedef struct packed {
    slot_st_e         status;
    logic [IdW-1:0]   ident;
  } entry_t;

  typedef struct packed {
    logic [IdW-1:0]   parent;
    logic [RunsW-1:0] runs;
  } info_t;

  typedef struct packed {
    logic             rd_en;
    logic [SlotW-1:0] rd_addr;
    logic [SlotW-1:0] wr_addr;
    logic             ent_we;
    entry_t           ent_wdata;
    logic             info_we;
    info_t            info_wdata;
    logic             stk_re;
    logic [SlotW-1:0] stk_raddr;
    logic             stk_we;
    logic [SlotW-1:0] stk_waddr;
    logic [SlotW-1:0] stk_wdata;
  } mem_req_t;

  typedef struct packed {
    entry_t           ent;
    info_t            info;
    logic [SlotW-1:0] stk;
  } mem_rsp_t;

  // Advances the generation above the index bits and places the slot index
  // in the low bits; a generation that wraps to zero or into the top bit
  // restarts at one.
  function automatic logic [IdW-1:0] next_ident(logic [IdW-1:0] old,
                                                logic [SlotW-1:0] idx);
    logic [GenW-1:0] sum;
    logic [GenW-1:0] gen;
    sum = {1'b0, old} + (GenW'(1) << GenShift);
    gen = sum & ~GenW'(NumSlots - 1);
    if (gen == '0 || gen[GenW-1]) begin
      gen = GenW'(1) << GenShift;
    end
    return gen[IdW-1:0] | IdW'(idx);
  endfunction

endpackage

`default_nettype wire

>>> hdl/pstg_in_if.sv
// Request channel of the slot table: valid/ready handshake and operands.
// Depends on pstg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pstg_in_if;
  logic                       valid;
  logic                       ready;
  logic [pstg_pkg::OpW-1:0]   opcode;
  logic [pstg_pkg::IdW-1:0]   query_id;
  logic                       check_perm;
  logic [pstg_pkg::IdW-1:0]   parent_ident;
  logic [pstg_pkg::TgtW-1:0]  target_slot;

  modport source (
    output valid, opcode, query_id, check_perm, parent_ident, target_slot,
    input  ready
  );

  modport sink (
    input  valid, opcode, query_id, check_perm, parent_ident, target_slot,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/pstg_out_if.sv
// Response channel of the slot table: valid/ready handshake and results.
// Depends on pstg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pstg_out_if;
  logic                       valid;
  logic                       ready;
  logic [pstg_pkg::StW-1:0]   status;
  logic [pstg_pkg::IdW-1:0]   result_id;
  logic [pstg_pkg::TgtW-1:0]  result_slot;
  logic                       marked_dying;
  logic [pstg_pkg::RunsW-1:0] runs_done;

  modport source (
    output valid, status, result_id, result_slot, marked_dying, runs_done,
    input  ready
  );

  modport sink (
    input  valid, status, result_id, result_slot, marked_dying, runs_done,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/pstg_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module pstg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hdl/pstg_ctrl.sv
// Sequencer of the slot table: clearing pass, read-modify-write of slot
// entries, free-slot bookkeeping and the result register. Uses pstg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pstg_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  pstg_in_if.sink                  in_i,
  pstg_out_if.source               out_o,
  output      pstg_pkg::mem_req_t  mem_req_o,
  input  wire pstg_pkg::mem_rsp_t  mem_rsp_i
);

  pstg_pkg::state_e                 state_q, state_d;
  logic [pstg_pkg::SlotW-1:0]       clr_q, clr_d;
  logic [pstg_pkg::CountW-1:0]      freed_cnt_q, freed_cnt_d;
  logic [pstg_pkg::CountW-1:0]      fresh_q, fresh_d;
  logic [pstg_pkg::SlotW-1:0]       cur_q, cur_d;
  logic                             cur_valid_q, cur_valid_d;
  logic [pstg_pkg::IdW-1:0]         cur_ident_q, cur_ident_d;
  logic                             full_q, full_d;
  logic [pstg_pkg::SlotW-1:0]       idx_q, idx_d;

  pstg_pkg::op_e                    op_q, op_d;
  logic [pstg_pkg::IdW-1:0]         qid_q, qid_d;
  logic                             perm_q, perm_d;
  logic [pstg_pkg::IdW-1:0]         parent_q, parent_d;
  logic [pstg_pkg::TgtW-1:0]        tgt_q, tgt_d;

  logic                             out_valid_q, out_valid_d;
  pstg_pkg::res_st_e                out_status_q, out_status_d;
  logic [pstg_pkg::IdW-1:0]         out_id_q, out_id_d;
  logic [pstg_pkg::TgtW-1:0]        out_slot_q, out_slot_d;
  logic                             out_dying_q, out_dying_d;
  logic [pstg_pkg::RunsW-1:0]       out_runs_q, out_runs_d;

  logic                             in_ready;
  logic                             out_free;
  logic [pstg_pkg::CountW-1:0]      cnt_dec;
  logic [pstg_pkg::SlotW-1:0]       tgt_idx;
  logic [pstg_pkg::SlotW-1:0]       lk_idx;
  logic                             tgt_ok;
  logic                             is_cur;
  logic [pstg_pkg::RunsW-1:0]       runs_inc;
  logic [pstg_pkg::IdW-1:0]         alloc_ident;
  pstg_pkg::entry_t                 ent;
  pstg_pkg::info_t                  info;

  assign ent         = mem_rsp_i.ent;
  assign info        = mem_rsp_i.info;
  assign cnt_dec     = freed_cnt_q - 1'b1;
  assign tgt_idx     = pstg_pkg::SlotW'(tgt_q);
  assign lk_idx      = qid_q[pstg_pkg::SlotW-1:0];
  assign tgt_ok      = 32'(tgt_q) < pstg_pkg::NumSlots;
  assign is_cur      = cur_valid_q && (cur_q == tgt_idx);
  assign runs_inc    = (&info.runs) ? info.runs : info.runs + 1'b1;
  assign alloc_ident = pstg_pkg::next_ident(ent.ident, idx_q);
  assign out_free    = !out_valid_q || out_o.ready;

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.result_id    = out_id_q;
  assign out_o.result_slot  = out_slot_q;
  assign out_o.marked_dying = out_dying_q;
  assign out_o.runs_done    = out_runs_q;

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    freed_cnt_d  = freed_cnt_q;
    fresh_d      = fresh_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    cur_ident_d  = cur_ident_q;
    full_d       = full_q;
    idx_d        = idx_q;
    op_d         = op_q;
    qid_d        = qid_q;
    perm_d       = perm_q;
    parent_d     = parent_q;
    tgt_d        = tgt_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_status_d = out_status_q;
    out_id_d     = out_id_q;
    out_slot_d   = out_slot_q;
    out_dying_d  = out_dying_q;
    out_runs_d   = out_runs_q;
    in_ready     = 1'b0;
    mem_req_o    = '0;

    unique case (state_q)
      pstg_pkg::ST_CLEAR: begin
        mem_req_o.ent_we    = 1'b1;
        mem_req_o.wr_addr   = clr_q;
        mem_req_o.ent_wdata = '{status: pstg_pkg::SS_FREE, ident: '0};
        clr_d = clr_q + 1'b1;
        if (clr_q == pstg_pkg::SlotW'(pstg_pkg::NumSlots - 1)) begin
          state_d = pstg_pkg::ST_IDLE;
        end
      end

      pstg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          op_d     = pstg_pkg::op_e'(in_i.opcode);
          qid_d    = in_i.query_id;
          perm_d   = in_i.check_perm;
          parent_d = in_i.parent_ident;
          tgt_d    = in_i.target_slot;
          full_d   = 1'b0;
          mem_req_o.rd_en     = 1'b1;
          mem_req_o.rd_addr   = (pstg_pkg::op_e'(in_i.opcode) == pstg_pkg::OP_LOOKUP) ?
                                in_i.query_id[pstg_pkg::SlotW-1:0] :
                                pstg_pkg::SlotW'(in_i.target_slot);
          mem_req_o.stk_re    = 1'b1;
          mem_req_o.stk_raddr = cnt_dec[pstg_pkg::SlotW-1:0];
          state_d = (pstg_pkg::op_e'(in_i.opcode) == pstg_pkg::OP_ALLOC) ?
                    pstg_pkg::ST_ALLOC : pstg_pkg::ST_EXEC;
        end
      end

      pstg_pkg::ST_ALLOC: begin
        priority if (freed_cnt_q != '0) begin
          idx_d             = mem_rsp_i.stk;
          freed_cnt_d       = cnt_dec;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = mem_rsp_i.stk;
        end else if (fresh_q < pstg_pkg::CountW'(pstg_pkg::NumSlots)) begin
          idx_d             = fresh_q[pstg_pkg::SlotW-1:0];
          fresh_d           = fresh_q + 1'b1;
          mem_req_o.rd_en   = 1'b1;
          mem_req_o.rd_addr = fresh_q[pstg_pkg::SlotW-1:0];
        end else begin
          full_d = 1'b1;
        end
        state_d = pstg_pkg::ST_EXEC;
      end

      pstg_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pstg_pkg::RS_OK;
          out_id_d     = '0;
          out_slot_d   = '0;
          out_dying_d  = 1'b0;
          out_runs_d   = '0;
          state_d      = pstg_pkg::ST_IDLE;
          unique case (op_q)
            pstg_pkg::OP_ALLOC: begin
              if (full_q) begin
                out_status_d = pstg_pkg::RS_FULL;
              end else begin
                mem_req_o.wr_addr    = idx_q;
                mem_req_o.ent_we     = 1'b1;
                mem_req_o.ent_wdata  = '{status: pstg_pkg::SS_RUNNABLE, ident: alloc_ident};
                mem_req_o.info_we    = 1'b1;
                mem_req_o.info_wdata = '{parent: parent_q, runs: '0};
                out_id_d   = alloc_ident;
                out_slot_d = pstg_pkg::TgtW'(idx_q);
              end
            end

            pstg_pkg::OP_LOOKUP: begin
              priority if (qid_q == '0) begin
                if (cur_valid_q) begin
                  out_id_d   = cur_ident_q;
                  out_slot_d = pstg_pkg::TgtW'(cur_q);
                end else begin
                  out_status_d = pstg_pkg::RS_BAD;
                end
              end else if (ent.status == pstg_pkg::SS_FREE || ent.ident != qid_q) begin
                out_status_d = pstg_pkg::RS_BAD;
              end else if (perm_q && !(cur_valid_q && lk_idx == cur_q) &&
                           !(cur_valid_q && info.parent == cur_ident_q)) begin
                out_status_d = pstg_pkg::RS_BAD;
              end else begin
                out_id_d   = qid_q;
                out_slot_d = pstg_pkg::TgtW'(lk_idx);
              end
            end

            pstg_pkg::OP_DESTROY: begin
              priority if (!tgt_ok || ent.status == pstg_pkg::SS_FREE) begin
                out_status_d = pstg_pkg::RS_BAD;
              end else if (ent.status == pstg_pkg::SS_RUNNING && !is_cur) begin
                mem_req_o.wr_addr   = tgt_idx;
                mem_req_o.ent_we    = 1'b1;
                mem_req_o.ent_wdata = '{status: pstg_pkg::SS_DYING, ident: ent.ident};
                out_dying_d = 1'b1;
              end else begin
                mem_req_o.wr_addr   = tgt_idx;
                mem_req_o.ent_we    = 1'b1;
                mem_req_o.ent_wdata = '{status: pstg_pkg::SS_FREE, ident: ent.ident};
                if (freed_cnt_q < pstg_pkg::CountW'(pstg_pkg::NumSlots)) begin
                  mem_req_o.stk_we    = 1'b1;
                  mem_req_o.stk_waddr = freed_cnt_q[pstg_pkg::SlotW-1:0];
                  mem_req_o.stk_wdata = tgt_idx;
                  freed_cnt_d = freed_cnt_q + 1'b1;
                end
                if (is_cur) begin
                  cur_valid_d = 1'b0;
                end
              end
            end

            pstg_pkg::OP_RUN: begin
              if (!tgt_ok || ent.status == pstg_pkg::SS_FREE) begin
                out_status_d = pstg_pkg::RS_BAD;
              end else begin
                mem_req_o.wr_addr    = tgt_idx;
                mem_req_o.ent_we     = 1'b1;
                mem_req_o.ent_wdata  = '{status: pstg_pkg::SS_RUNNING, ident: ent.ident};
                mem_req_o.info_we    = 1'b1;
                mem_req_o.info_wdata = '{parent: info.parent, runs: runs_inc};
                out_id_d   = ent.ident;
                out_slot_d = tgt_q;
                out_runs_d = runs_inc;
                if (cur_valid_q && cur_q != tgt_idx) begin
                  state_d = pstg_pkg::ST_FIX;
                end else begin
                  cur_d       = tgt_idx;
                  cur_valid_d = 1'b1;
                  cur_ident_d = ent.ident;
                end
              end
            end

            default: begin
              out_status_d = pstg_pkg::RS_BAD;
            end
          endcase
        end
      end

      pstg_pkg::ST_FIX: begin
        // The slot that was current is always running here; it steps back
        // to runnable before the new slot takes over.
        mem_req_o.wr_addr   = cur_q;
        mem_req_o.ent_we    = 1'b1;
        mem_req_o.ent_wdata = '{status: pstg_pkg::SS_RUNNABLE, ident: cur_ident_q};
        cur_d       = tgt_idx;
        cur_valid_d = 1'b1;
        cur_ident_d = ent.ident;
        state_d     = pstg_pkg::ST_IDLE;
      end

      default: begin
        state_d = pstg_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pstg_pkg::ST_CLEAR;
      clr_q       <= '0;
      freed_cnt_q <= '0;
      fresh_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_ident_q <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      freed_cnt_q <= freed_cnt_d;
      fresh_q     <= fresh_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      cur_ident_q <= cur_ident_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    op_q         <= op_d;
    qid_q        <= qid_d;
    perm_q       <= perm_d;
    parent_q     <= parent_d;
    tgt_q        <= tgt_d;
    out_status_q <= out_status_d;
    out_id_q     <= out_id_d;
    out_slot_q   <= out_slot_d;
    out_dying_q  <= out_dying_d;
    out_runs_q   <= out_runs_d;
  end

endmodule

`default_nettype wire

>>> hdl/process_slot_table_with_generation_ids_top.sv
// Top level of the process slot table: sequencer plus the entry, info and
// freed-slot memories. Uses pstg_pkg, pstg_in_if, pstg_out_if, pstg_ram, pstg_ctrl.
//
//   channel  direction  contents
//   in_i     sink       opcode, query_id, check_perm, parent_ident, target_slot
//   out_o    source     status, result_id, result_slot, marked_dying, runs_done
//
// Lookup and destroy issue the entry read on acceptance and register the result
// in ST_EXEC; allocate passes through ST_ALLOC first (the freed-slot stack read
// precedes the entry read). A run also registers its result in ST_EXEC; one that
// displaces another current slot holds in_i.ready low through ST_FIX for a second
// entry write. After reset a clearing pass writes every entry with in_i.ready low.
// A result waits in the output register; a new transaction is accepted meanwhile,
// and its result is held back until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module process_slot_table_with_generation_ids_top (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  pstg_in_if.sink    in_i,
  pstg_out_if.source out_o
);

  pstg_pkg::mem_req_t mem_req;
  pstg_pkg::mem_rsp_t mem_rsp;
  pstg_pkg::entry_t   ent_rdata;
  pstg_pkg::info_t    info_rdata;
  logic [pstg_pkg::SlotW-1:0] stk_rdata;

  assign mem_rsp.ent  = ent_rdata;
  assign mem_rsp.info = info_rdata;
  assign mem_rsp.stk  = stk_rdata;

  pstg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp)
  );

  pstg_ram #(
    .Width ($bits(pstg_pkg::entry_t)),
    .Depth (pstg_pkg::NumSlots)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.ent_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.ent_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (ent_rdata)
  );

  pstg_ram #(
    .Width ($bits(pstg_pkg::info_t)),
    .Depth (pstg_pkg::NumSlots)
  ) u_info_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.info_we),
    .waddr_i (mem_req.wr_addr),
    .wdata_i (mem_req.info_wdata),
    .re_i    (mem_req.rd_en),
    .raddr_i (mem_req.rd_addr),
    .rdata_o (info_rdata)
  );

  pstg_ram #(
    .Width (pstg_pkg::SlotW),
    .Depth (pstg_pkg::NumSlots)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.stk_we),
    .waddr_i (mem_req.stk_waddr),
    .wdata_i (mem_req.stk_wdata),
    .re_i    (mem_req.stk_re),
    .raddr_i (mem_req.stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Reads and writes of the slot memories fall in different cycles.
  `ASSERT_IMPLIES(a_ent_no_rw_overlap, clk_i, rst_ni,
                  mem_req.ent_we || mem_req.info_we, !mem_req.rd_en)
  `ASSERT_IMPLIES(a_stk_no_rw_overlap, clk_i, rst_ni, mem_req.stk_we, !mem_req.stk_re)
  // Only one transaction is in flight at a time.
  `ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

endmodule

`default_nettype wire
